// File: hw/rtl/sstc_pkg.sv
// ----------------------------------------------------------------------------
// sstc_pkg: shared types and constants for the series sine/cosine/tangent unit
// Holds the transaction structs, command and register codes, the sequencer
// state type and the default values of the top-level parameters.
// ----------------------------------------------------------------------------
package sstc_pkg;

  // Default parameter values.
  localparam int MAX_TERMS_DEF = 7;
  localparam int FRAC_BITS_DEF = 30;

  // pi scaled by 2^60, rounded down; rescaled to the working format at elaboration.
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Command codes.
  localparam logic [1:0] CMD_SIN = 2'd0;
  localparam logic [1:0] CMD_COS = 2'd1;
  localparam logic [1:0] CMD_TAN = 2'd2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int LIMIT_W    = 31;
  localparam int COUNT_W    = 3;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_POLE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT     = 2'd1;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = 31'd107;
  localparam logic [COUNT_W-1:0]   COUNT_RESET        = 3'd7;

  // Tangent quotient: 63 fraction-and-integer bits remain after the overflow check.
  localparam int DIV_STEPS = 63;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               pole;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_INIT,
    ST_TA_GO,
    ST_TA_WAIT,
    ST_TB_GO,
    ST_TB_WAIT,
    ST_END,
    ST_TAN,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/sstc_mul.sv
// ----------------------------------------------------------------------------
// sstc_mul: iterative fixed-point multiplier
// Forms a rounded, saturated signed product from four 32x32 partial products,
// one per cycle, and presents it with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module sstc_mul #(
  parameter int FRAC_BITS = sstc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] result
);

  localparam logic [127:0] ROUND = 128'd1 << (FRAC_BITS - 1);

  logic [63:0]        amag_r, bmag_r;
  logic               neg_r;
  logic [127:0]       acc_r;
  logic [2:0]         cnt_r;
  logic               run_r;
  logic               done_r;
  logic signed [63:0] result_r;

  logic [31:0]  xs, ys;
  logic [63:0]  pp;
  logic [127:0] aligned;
  logic [63:0]  rnd;
  logic         sat;
  logic [63:0]  mag;
  logic [63:0]  res;

  always_comb begin
    xs = cnt_r[0] ? amag_r[63:32] : amag_r[31:0];
    ys = cnt_r[1] ? bmag_r[63:32] : bmag_r[31:0];
    pp = xs * ys;
    case (cnt_r[1:0])
      2'd0:    aligned = {64'd0, pp};
      2'd1:    aligned = {32'd0, pp, 32'd0};
      2'd2:    aligned = {32'd0, pp, 32'd0};
      default: aligned = {pp, 64'd0};
    endcase
  end

  // The rounding constant is preloaded, so only the final shift, clamp and sign restore remain.
  always_comb begin
    rnd = acc_r[FRAC_BITS +: 64];
    sat = |(acc_r >> (64 + FRAC_BITS));
    mag = (sat || rnd[63]) ? {1'b0, {63{1'b1}}} : rnd;
    res = neg_r ? (64'd0 - mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        amag_r <= a[63] ? (64'd0 - a) : a;
        bmag_r <= b[63] ? (64'd0 - b) : b;
        neg_r  <= a[63] ^ b[63];
        acc_r  <= ROUND;
        cnt_r  <= 3'd0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (cnt_r == 3'd4) begin
          result_r <= res;
          done_r   <= 1'b1;
          run_r    <= 1'b0;
        end else begin
          acc_r <= acc_r + aligned;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

// File: hw/rtl/sstc_div.sv
// ----------------------------------------------------------------------------
// sstc_div: serial restoring divider for the tangent quotient
// Computes floor(ns * 2^32 / nc) one bit per cycle, given that the quotient
// is known to stay below 2^63.
// ----------------------------------------------------------------------------
module sstc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] ns,
  input  logic [63:0] nc,
  output logic        done,
  output logic [62:0] quotient
);

  localparam int CW = $clog2(sstc_pkg::DIV_STEPS);

  logic [63:0]   rem_r;
  logic [62:0]   dvd_r;
  logic [63:0]   nc_r;
  logic [62:0]   q_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, dvd_r[62]};
    diff   = rem_sh - {1'b0, nc_r};
    ge     = rem_sh >= {1'b0, nc_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // The top 33 dividend bits are already below the divisor.
        rem_r <= {31'd0, ns[63:31]};
        dvd_r <= {ns[30:0], 32'd0};
        nc_r  <= nc;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? diff[63:0] : rem_sh[63:0];
        dvd_r <= {dvd_r[61:0], 1'b0};
        q_r   <= {q_r[61:0], ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(sstc_pkg::DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: hw/rtl/series_sine_cosine_tangent.sv
// ----------------------------------------------------------------------------
// series_sine_cosine_tangent: Maclaurin-series sine, cosine and tangent
// Reduces a Q8.24 angle into [-pi, pi], sums the sine or cosine series on one
// shared iterative multiplier and, for tangent, divides sine by cosine on a
// serial divider. The result is a saturating signed Q31.32 value.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                          Transaction taken when
//   -------  -----------------------------  ---------------------------------
//   input    start, busy, in_data           start high and busy low
//   result   out_valid, out_data            out_valid high (one cycle only)
//   config   cfg_we, cfg_index, cfg_wdata   cfg_we high
//
// Each product on the shared multiplier passes through issue, four partial
// products, rounding and hand-back. Sine or cosine keeps busy high through
// the angle reduction and its full-turn corrections, the squaring of the
// angle and two products per series term; tangent sums the cosine and then
// the sine series and divides on the serial divider, which a tangent that
// hits the pole limit or saturates skips.
// Reset is synchronous and active low; it returns the sequencer to idle and
// loads the register defaults. The receiver cannot stall: each result is
// flagged by out_valid for exactly one cycle, after which busy falls and a new
// transaction may start.
// ----------------------------------------------------------------------------
module series_sine_cosine_tangent #(
  parameter int MAX_TERMS = sstc_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = sstc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  sstc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output sstc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [sstc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sstc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Term index and term count widths follow from the series length.
  localparam int KW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  // pi in the working format, rounded to nearest, and one full turn.
  localparam logic signed [63:0] PI_FX =
    64'((sstc_pkg::PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
  localparam logic signed [63:0] TWO_PI = PI_FX <<< 1;
  localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

  // Shift amounts for the format conversions; the unused one is held at a
  // harmless value so that every branch elaborates.
  localparam int ANG_SHL  = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int ANG_SHR  = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam int Q32_SHL  = (FRAC_BITS <= 32) ? 32 - FRAC_BITS : 0;
  localparam int Q32_SHR  = (FRAC_BITS > 32) ? FRAC_BITS - 32 : 1;
  localparam logic [63:0] Q32_HALF = 64'd1 << (Q32_SHR - 1);
  localparam int LIM_SHL  = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int LIM_SHR  = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;

  // --------------------------------------------------------------------------
  // Reciprocal tables. Term n of sine divides by (2n)(2n+1), term n of
  // cosine by (2n-1)(2n); both reciprocals are rounded to nearest.
  // --------------------------------------------------------------------------
  logic [63:0] recip_sin_c [MAX_TERMS];
  logic [63:0] recip_cos_c [MAX_TERMS];

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_recip
    localparam logic [63:0] DSIN = 64'((2 * (k + 1)) * (2 * (k + 1) + 1));
    localparam logic [63:0] DCOS = 64'((2 * (k + 1) - 1) * (2 * (k + 1)));
    localparam logic [63:0] RSIN = ((64'd1 << FRAC_BITS) + DSIN / 2) / DSIN;
    localparam logic [63:0] RCOS = ((64'd1 << FRAC_BITS) + DCOS / 2) / DCOS;
    assign recip_sin_c[k] = RSIN;
    assign recip_cos_c[k] = RCOS;
  end

  // --------------------------------------------------------------------------
  // Configuration registers. Writes to indexes beyond the list are dropped.
  // --------------------------------------------------------------------------
  logic [sstc_pkg::LIMIT_W-1:0] limit_r;
  logic [sstc_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sstc_pkg::LIMIT_RESET;
      count_r <= sstc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sstc_pkg::REG_TAN_POLE_LIMIT: limit_r <= cfg_wdata[sstc_pkg::LIMIT_W-1:0];
        sstc_pkg::REG_TERM_COUNT:     count_r <= cfg_wdata[sstc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Number of series terms added after the first, capped at the table length.
  logic [CW-1:0] terms_c;
  assign terms_c = (count_r < MAX_TERMS) ? CW'(count_r) : CW'(MAX_TERMS);

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // --------------------------------------------------------------------------
  sstc_pkg::state_t state_r, state_nxt;

  logic [1:0]         cmd_r;
  logic               pass_cos_r;   // the series in progress is the cosine
  logic signed [63:0] x_r;          // reduced angle
  logic signed [63:0] x2_r;         // angle squared
  logic signed [63:0] term_r;
  logic signed [63:0] prod_r;       // term times angle squared
  logic signed [63:0] sum_r;
  logic signed [63:0] cos_r;        // cosine kept for the tangent
  logic [KW-1:0]      k_r;
  logic               neg_r;
  logic signed [63:0] value_r;
  logic               pole_r;

  // Shared units.
  logic               mul_start;
  logic signed [63:0] mul_a, mul_b;
  logic               mul_done;
  logic signed [63:0] mul_res;
  logic               div_start;
  logic               div_done;
  logic [62:0]        div_q;

  logic               accept;
  logic               last_term;
  logic signed [63:0] angle_ext;
  logic signed [63:0] angle_fx;
  logic [63:0]        recip_c;
  logic [63:0]        ns_c, nc_c;
  logic [63:0]        lim_c;
  logic               pole_c;
  logic               ovf_c;
  logic [63:0]        sum_mag;
  logic [63:0]        q32_rnd;
  logic signed [63:0] q32_c;

  assign accept    = start && (state_r == sstc_pkg::ST_IDLE);
  assign last_term = (CW'(k_r) + CW'(1)) == terms_c;
  assign recip_c   = pass_cos_r ? recip_cos_c[k_r] : recip_sin_c[k_r];

  // Q8.24 angle into the working format: exact left shift, or floor shift.
  always_comb begin
    angle_ext = 64'(in_data.angle);
    if (FRAC_BITS >= 24) begin
      angle_fx = angle_ext <<< ANG_SHL;
    end else begin
      angle_fx = angle_ext >>> ANG_SHR;
    end
  end

  // Series sum into Q31.32, rounding halves away from zero when narrowing.
  always_comb begin
    sum_mag = sum_r[63] ? (64'd0 - sum_r) : sum_r;
    q32_rnd = (sum_mag + Q32_HALF) >> Q32_SHR;
    if (FRAC_BITS <= 32) begin
      q32_c = sum_r <<< Q32_SHL;
    end else begin
      q32_c = sum_r[63] ? (64'sd0 - q32_rnd) : q32_rnd;
    end
  end

  // Tangent checks: sum_r holds the sine and cos_r the cosine by now.
  always_comb begin
    ns_c = sum_r[63] ? (64'd0 - sum_r) : sum_r;
    nc_c = cos_r[63] ? (64'd0 - cos_r) : cos_r;
    if (FRAC_BITS >= 30) begin
      lim_c = {33'd0, limit_r} << LIM_SHL;
    end else begin
      lim_c = {33'd0, limit_r} >> LIM_SHR;
    end
    pole_c = (nc_c == 64'd0) || (nc_c < lim_c);
    // The integer part of the quotient reaches 2^31 exactly when ns >= nc * 2^31.
    ovf_c  = {31'd0, ns_c} >= {nc_c, 31'd0};
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sstc_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == sstc_pkg::CMD_SIN || in_data.command == sstc_pkg::CMD_COS ||
              in_data.command == sstc_pkg::CMD_TAN) begin
            state_nxt = sstc_pkg::ST_REDUCE;
          end else begin
            state_nxt = sstc_pkg::ST_OUT;
          end
        end
      end
      sstc_pkg::ST_REDUCE: begin
        if (x_r <= PI_FX && x_r >= -PI_FX) begin
          state_nxt = sstc_pkg::ST_SQ_GO;
        end
      end
      sstc_pkg::ST_SQ_GO:   state_nxt = sstc_pkg::ST_SQ_WAIT;
      sstc_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          state_nxt = sstc_pkg::ST_INIT;
        end
      end
      sstc_pkg::ST_INIT: begin
        state_nxt = (terms_c == '0) ? sstc_pkg::ST_END : sstc_pkg::ST_TA_GO;
      end
      sstc_pkg::ST_TA_GO:   state_nxt = sstc_pkg::ST_TA_WAIT;
      sstc_pkg::ST_TA_WAIT: begin
        if (mul_done) begin
          state_nxt = sstc_pkg::ST_TB_GO;
        end
      end
      sstc_pkg::ST_TB_GO:   state_nxt = sstc_pkg::ST_TB_WAIT;
      sstc_pkg::ST_TB_WAIT: begin
        if (mul_done) begin
          state_nxt = last_term ? sstc_pkg::ST_END : sstc_pkg::ST_TA_GO;
        end
      end
      sstc_pkg::ST_END: begin
        if (cmd_r == sstc_pkg::CMD_TAN) begin
          state_nxt = pass_cos_r ? sstc_pkg::ST_INIT : sstc_pkg::ST_TAN;
        end else begin
          state_nxt = sstc_pkg::ST_OUT;
        end
      end
      sstc_pkg::ST_TAN: begin
        state_nxt = (pole_c || ovf_c) ? sstc_pkg::ST_OUT : sstc_pkg::ST_DIV_WAIT;
      end
      sstc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = sstc_pkg::ST_OUT;
        end
      end
      sstc_pkg::ST_OUT: state_nxt = sstc_pkg::ST_IDLE;
      default:          state_nxt = sstc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: unit starts and the multiplier operand selection.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = term_r;
    mul_b     = x2_r;
    div_start = 1'b0;
    case (state_r)
      sstc_pkg::ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = x_r;
        mul_b     = x_r;
      end
      sstc_pkg::ST_TA_GO: begin
        mul_start = 1'b1;
      end
      sstc_pkg::ST_TB_GO: begin
        mul_start = 1'b1;
        mul_a     = prod_r;
        mul_b     = recip_c;
      end
      sstc_pkg::ST_TAN: begin
        div_start = !(pole_c || ovf_c);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sstc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers carry no reset; the sequencer loads them before use.
  always_ff @(posedge clk) begin
    case (state_r)
      sstc_pkg::ST_IDLE: begin
        cmd_r      <= in_data.command;
        pass_cos_r <= (in_data.command != sstc_pkg::CMD_SIN);
        x_r        <= angle_fx;
        value_r    <= 64'sd0;
        pole_r     <= 1'b0;
      end
      sstc_pkg::ST_REDUCE: begin
        // A value above pi stays above -pi after one subtraction, so at most
        // one direction of correction is ever taken.
        if (x_r > PI_FX) begin
          x_r <= x_r - TWO_PI;
        end else if (x_r < -PI_FX) begin
          x_r <= x_r + TWO_PI;
        end
      end
      sstc_pkg::ST_SQ_WAIT: begin
        if (mul_done) begin
          x2_r <= mul_res;
        end
      end
      sstc_pkg::ST_INIT: begin
        term_r <= pass_cos_r ? ONE_FX : x_r;
        sum_r  <= pass_cos_r ? ONE_FX : x_r;
        k_r    <= '0;
      end
      sstc_pkg::ST_TA_WAIT: begin
        if (mul_done) begin
          prod_r <= mul_res;
        end
      end
      sstc_pkg::ST_TB_WAIT: begin
        if (mul_done) begin
          term_r <= -mul_res;
          sum_r  <= sum_r - mul_res;
          k_r    <= k_r + KW'(1);
        end
      end
      sstc_pkg::ST_END: begin
        if (cmd_r == sstc_pkg::CMD_TAN) begin
          // The cosine is summed first; the sine follows on the same square.
          if (pass_cos_r) begin
            cos_r      <= sum_r;
            pass_cos_r <= 1'b0;
          end
        end else begin
          value_r <= q32_c;
          pole_r  <= 1'b0;
        end
      end
      sstc_pkg::ST_TAN: begin
        neg_r <= sum_r[63] ^ cos_r[63];
        if (pole_c) begin
          value_r <= 64'sd0;
          pole_r  <= 1'b1;
        end else if (ovf_c) begin
          value_r <= (sum_r[63] ^ cos_r[63]) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          pole_r  <= 1'b0;
        end
      end
      sstc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          value_r <= neg_r ? (64'sd0 - {1'b0, div_q}) : {1'b0, div_q};
          pole_r  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  sstc_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  sstc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .ns       (ns_c),
    .nc       (nc_c),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy           = (state_r != sstc_pkg::ST_IDLE);
  assign out_valid      = (state_r == sstc_pkg::ST_OUT);
  assign out_data.value = value_r;
  assign out_data.pole  = pole_r;

endmodule

// File: hw/rtl/sstc_checker.sv
// ----------------------------------------------------------------------------
// sstc_checker: port-level assertions for the series sine/cosine/tangent unit
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module sstc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input sstc_pkg::out_item_t out_data
);

  // An accepted transaction makes the unit busy.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // A result only appears while a transaction is in flight.
  a_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe without a transaction in flight");

  // The strobe lasts one cycle and ends the transaction.
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe held or unit still busy after result");

  // A pole result always carries a zero value.
  a_pole_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pole) |-> (out_data.value == 64'sd0))
    else $error("pole flagged with a nonzero value");

endmodule

bind series_sine_cosine_tangent sstc_checker u_sstc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
